[rtl/core/vkvfl_pkg.sv]
// shared types and constants for the versioned key/value floor lookup
`timescale 1ns / 1ps

package vkvfl_pkg;

  localparam int KEY_SLOTS       = 16;
  localparam int ENTRIES_PER_KEY = 64;
  localparam int KEY_W           = $clog2(KEY_SLOTS);
  localparam int IDX_W           = $clog2(ENTRIES_PER_KEY);
  localparam int CNT_W           = IDX_W + 1;
  localparam int ADDR_W          = KEY_W + IDX_W;
  localparam int STORE_DEPTH     = KEY_SLOTS * ENTRIES_PER_KEY;
  localparam int STAMP_W         = 31;
  localparam int VAL_W           = 32;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES_PER_KEY);

  localparam logic OP_SET = 1'b0;
  localparam logic OP_GET = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_ORDER     = 2'd3
  } status_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [STAMP_W-1:0] stamp;
    logic [VAL_W-1:0]  value;
  } mem_wr_t;

  typedef struct packed {
    logic             inc;
    logic [KEY_W-1:0] key;
  } cnt_upd_t;

endpackage

[rtl/core/vkvfl_store.sv]
// stamp and value memories with one write port and one registered read port
`timescale 1ns / 1ps

module vkvfl_store
  import vkvfl_pkg::*;
(
  input  logic               clk,
  input  mem_wr_t            wr,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [STAMP_W-1:0] rd_stamp,
  output logic [VAL_W-1:0]   rd_value
);

  logic [STAMP_W-1:0] stamp_mem [STORE_DEPTH];
  logic [VAL_W-1:0]   value_mem [STORE_DEPTH];
  logic [STAMP_W-1:0] rd_stamp_r;
  logic [VAL_W-1:0]   rd_value_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      stamp_mem[wr.addr] <= wr.stamp;
      value_mem[wr.addr] <= wr.value;
    end
  end

  always_ff @(posedge clk) begin
    rd_stamp_r <= stamp_mem[rd_addr];
    rd_value_r <= value_mem[rd_addr];
  end

  assign rd_stamp = rd_stamp_r;
  assign rd_value = rd_value_r;

endmodule

[rtl/core/vkvfl_ctrl.sv]
// sequencer: append check and binary search over one slot with a shared compare
`timescale 1ns / 1ps

module vkvfl_ctrl
  import vkvfl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_operation,
  input  logic [KEY_W-1:0]   in_key_id,
  input  logic [STAMP_W-1:0] in_stamp,
  input  logic [VAL_W-1:0]   in_write_value,
  input  logic [CNT_W-1:0]   slot_count,
  input  logic [STAMP_W-1:0] rd_stamp,
  input  logic [VAL_W-1:0]   rd_value,
  output logic               busy,
  output mem_wr_t            mem_wr,
  output logic [ADDR_W-1:0]  rd_addr,
  output cnt_upd_t           cnt_upd,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [VAL_W-1:0]   out_read_value
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SRD  = 6'b000010,
    S_SCMP = 6'b000100,
    S_GRD  = 6'b001000,
    S_GCMP = 6'b010000,
    S_GVAL = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt;
  logic [VAL_W-1:0]   wval_r, wval_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   lo_r, lo_nxt;
  logic [CNT_W-1:0]   hi_r, hi_nxt;
  logic               valid_r, valid_nxt;
  status_t            status_r, status_nxt;
  logic [VAL_W-1:0]   rval_r, rval_nxt;

  logic [CNT_W-1:0]   mid;
  logic [CNT_W-1:0]   last_idx;
  logic [CNT_W-1:0]   lo_dec;
  logic [STAMP_W-1:0] cmp_a;
  logic [STAMP_W-1:0] cmp_b;
  logic               stamp_le;

  assign mid      = lo_r + ((hi_r - lo_r) >> 1);
  assign last_idx = n_r - CNT_W'(1);
  assign lo_dec   = lo_r - CNT_W'(1);
  // append check: new stamp not above last; search: entry not above query
  assign cmp_a    = (state_r == S_SCMP) ? stamp_r : rd_stamp;
  assign cmp_b    = (state_r == S_SCMP) ? rd_stamp : stamp_r;
  assign stamp_le = (cmp_a <= cmp_b);

  always_comb begin
    state_nxt  = state_r;
    key_nxt    = key_r;
    stamp_nxt  = stamp_r;
    wval_nxt   = wval_r;
    n_nxt      = n_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    valid_nxt  = 1'b0;
    status_nxt = status_r;
    rval_nxt   = '0;
    mem_wr     = '0;
    rd_addr    = {key_r, mid[IDX_W-1:0]};
    cnt_upd    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt   = in_key_id;
          stamp_nxt = in_stamp;
          wval_nxt  = in_write_value;
          n_nxt     = slot_count;
          lo_nxt    = '0;
          hi_nxt    = slot_count;
          if (in_operation == OP_SET) begin
            if (slot_count == CNT_FULL) begin
              valid_nxt  = 1'b1;
              status_nxt = ST_FULL;
            end else if (slot_count == '0) begin
              mem_wr.en    = 1'b1;
              mem_wr.addr  = {in_key_id, IDX_W'(0)};
              mem_wr.stamp = in_stamp;
              mem_wr.value = in_write_value;
              cnt_upd.inc  = 1'b1;
              cnt_upd.key  = in_key_id;
              valid_nxt    = 1'b1;
              status_nxt   = ST_OK;
            end else begin
              state_nxt = S_SRD;
            end
          end else begin
            state_nxt = S_GRD;
          end
        end
      end
      S_SRD: begin
        rd_addr   = {key_r, last_idx[IDX_W-1:0]};
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        valid_nxt = 1'b1;
        state_nxt = S_IDLE;
        if (stamp_le) begin
          status_nxt = ST_ORDER;
        end else begin
          mem_wr.en    = 1'b1;
          mem_wr.addr  = {key_r, n_r[IDX_W-1:0]};
          mem_wr.stamp = stamp_r;
          mem_wr.value = wval_r;
          cnt_upd.inc  = 1'b1;
          cnt_upd.key  = key_r;
          status_nxt   = ST_OK;
        end
      end
      S_GRD: begin
        if (lo_r < hi_r) begin
          state_nxt = S_GCMP;
        end else if (lo_r == '0) begin
          valid_nxt  = 1'b1;
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_IDLE;
        end else begin
          rd_addr   = {key_r, lo_dec[IDX_W-1:0]};
          state_nxt = S_GVAL;
        end
      end
      S_GCMP: begin
        if (stamp_le) begin
          lo_nxt = mid + CNT_W'(1);
        end else begin
          hi_nxt = mid;
        end
        state_nxt = S_GRD;
      end
      S_GVAL: begin
        valid_nxt  = 1'b1;
        status_nxt = ST_OK;
        rval_nxt   = rd_value;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    stamp_r  <= stamp_nxt;
    wval_r   <= wval_nxt;
    n_r      <= n_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    status_r <= status_nxt;
    rval_r   <= rval_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = valid_r;
  assign out_status     = status_r;
  assign out_read_value = rval_r;

endmodule

[rtl/core/versioned_key_value_floor_lookup.sv]
// top level: per-slot entry counts, search sequencer and entry memories
`timescale 1ns / 1ps
//
// Versioned key/value store with floor lookup by timestamp.
// A command is taken when start is high and busy is low. A set appends
// (in_stamp, in_write_value) to slot in_key_id; it is refused with status
// slot full or timestamp out of order. A get returns the value of the entry
// with the greatest stamp not above in_stamp, or status not found.
// Each command gives one result: out_valid is high for one cycle with
// out_status and out_read_value (zero unless a get succeeds).
// A set on a full or empty slot answers in the cycle after the transfer;
// any other set first reads the last entry, then compares. Each binary
// search step of a get issues a read on the single memory read port, then
// compares; a 64-entry slot takes up to 7 steps, then a value read. busy stays
// high until the result is out, so one command is in flight at a time.
// The receiver cannot stall; the result is shown for exactly one cycle.
// Reset clears all slot counts and the sequencer; memory contents are not
// cleared and are only read below a slot's count.
//

module versioned_key_value_floor_lookup
  import vkvfl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_operation,
  input  logic [KEY_W-1:0]   in_key_id,
  input  logic [STAMP_W-1:0] in_stamp,
  input  logic [VAL_W-1:0]   in_write_value,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [VAL_W-1:0]   out_read_value
);

  logic [CNT_W-1:0]   count_r [KEY_SLOTS];
  mem_wr_t            mem_wr;
  cnt_upd_t           cnt_upd;
  logic [ADDR_W-1:0]  rd_addr;
  logic [STAMP_W-1:0] rd_stamp;
  logic [VAL_W-1:0]   rd_value;
  logic               ctrl_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        count_r[i] <= '0;
      end
    end else if (cnt_upd.inc) begin
      count_r[cnt_upd.key] <= count_r[cnt_upd.key] + CNT_W'(1);
    end
  end

  vkvfl_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start & ~ctrl_busy),
    .in_operation   (in_operation),
    .in_key_id      (in_key_id),
    .in_stamp       (in_stamp),
    .in_write_value (in_write_value),
    .slot_count     (count_r[in_key_id]),
    .rd_stamp       (rd_stamp),
    .rd_value       (rd_value),
    .busy           (ctrl_busy),
    .mem_wr         (mem_wr),
    .rd_addr        (rd_addr),
    .cnt_upd        (cnt_upd),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_read_value (out_read_value)
  );

  vkvfl_store u_store (
    .clk      (clk),
    .wr       (mem_wr),
    .rd_addr  (rd_addr),
    .rd_stamp (rd_stamp),
    .rd_value (rd_value)
  );

  assign busy = ctrl_busy;

endmodule

[tb/vkvfl_checker.sv]
// checker for the versioned key/value floor lookup: predicts every command and compares results
`timescale 1ns / 1ps

module vkvfl_checker
  import vkvfl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_operation,
  input  logic [KEY_W-1:0]   in_key_id,
  input  logic [STAMP_W-1:0] in_stamp,
  input  logic [VAL_W-1:0]   in_write_value,
  input  logic               out_valid,
  input  logic [1:0]         out_status,
  input  logic [VAL_W-1:0]   out_read_value,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    status_t           status;
    logic [VAL_W-1:0]  value;
  } reply_t;

  localparam int DUE_DEPTH = 8;

  logic [CNT_W-1:0]   model_fill  [KEY_SLOTS];
  logic [STAMP_W-1:0] model_stamp [KEY_SLOTS][ENTRIES_PER_KEY];
  logic [VAL_W-1:0]   model_value [KEY_SLOTS][ENTRIES_PER_KEY];

  reply_t replies_due [DUE_DEPTH];
  int     due_wr     = 0;
  int     due_rd     = 0;
  int     mismatches = 0;

  task automatic report_mismatch(input string what);
    if (mismatches < 40) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  // entries of the slot whose stamp is not above the query; stamps rise strictly
  function automatic int entries_at_or_below(logic [KEY_W-1:0] key, logic [STAMP_W-1:0] query);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = int'(model_fill[key]);
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (model_stamp[key][mid] <= query) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    return lo;
  endfunction

  function automatic reply_t execute_command(logic op, logic [KEY_W-1:0] key,
                                             logic [STAMP_W-1:0] stamp,
                                             logic [VAL_W-1:0] value);
    reply_t r;
    int     fill;
    int     hits;
    r.status = ST_OK;
    r.value  = '0;
    fill     = int'(model_fill[key]);
    if (op == OP_SET) begin
      if (fill >= ENTRIES_PER_KEY) begin
        r.status = ST_FULL;
      end else if (fill > 0 && stamp <= model_stamp[key][fill-1]) begin
        r.status = ST_ORDER;
      end else begin
        model_stamp[key][fill] = stamp;
        model_value[key][fill] = value;
        model_fill[key]        = model_fill[key] + 1'b1;
      end
    end else begin
      hits = entries_at_or_below(key, stamp);
      if (hits == 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        r.value = model_value[key][hits-1];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    reply_t due;
    if (!rst_n) begin
      due_wr = 0;
      due_rd = 0;
      for (int k = 0; k < KEY_SLOTS; k++) begin
        model_fill[k] = '0;
      end
    end else begin
      if (out_valid) begin
        if (due_wr == due_rd) begin
          report_mismatch($sformatf("result with nothing awaited: status %0d value %h",
                                    out_status, out_read_value));
        end else begin
          due = replies_due[due_rd % DUE_DEPTH];
          due_rd++;
          if (out_status !== due.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", out_status, due.status));
          end
          if (out_read_value !== due.value) begin
            report_mismatch($sformatf("read value %h, expected %h", out_read_value, due.value));
          end
        end
      end
      // command transfer
      if (start && !busy) begin
        replies_due[due_wr % DUE_DEPTH] = execute_command(in_operation, in_key_id, in_stamp,
                                                          in_write_value);
        due_wr++;
      end
    end
    fail_count <= mismatches;
    pending    <= due_wr - due_rd;
  end

endmodule

[tb/tb.sv]
// testbench top: clock, reset, command stimulus and the final verdict
`timescale 1ns / 1ps

module tb;
  import vkvfl_pkg::*;

  localparam int                 RANDOM_COMMANDS = 1930;
  localparam int                 CYCLE_LIMIT     = 400000;
  localparam int                 SETTLE_CYCLES   = 20;
  localparam logic [STAMP_W-1:0] STAMP_MAX       = {STAMP_W{1'b1}};

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               start          = 1'b0;
  logic               busy;
  logic               in_operation   = OP_SET;
  logic [KEY_W-1:0]   in_key_id      = '0;
  logic [STAMP_W-1:0] in_stamp       = '0;
  logic [VAL_W-1:0]   in_write_value = '0;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [VAL_W-1:0]   out_read_value;
  int                 fail_count;
  int                 pending;
  int                 cycles         = 0;
  bit                 back_to_back   = 1'b0;

  // stimulus-side view of what each slot holds, used to aim stamps
  int                 slot_fill   [KEY_SLOTS];
  logic [STAMP_W-1:0] slot_stamps [KEY_SLOTS][ENTRIES_PER_KEY];

  versioned_key_value_floor_lookup dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_key_id      (in_key_id),
    .in_stamp       (in_stamp),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_read_value (out_read_value)
  );

  vkvfl_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_key_id      (in_key_id),
    .in_stamp       (in_stamp),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_command(input logic op, input int key, input logic [STAMP_W-1:0] stamp,
                              input logic [VAL_W-1:0] value);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start          <= 1'b1;
    in_operation   <= op;
    in_key_id      <= key[KEY_W-1:0];
    in_stamp       <= stamp;
    in_write_value <= value;
    do @(posedge clk); while (busy);
    if (op == OP_SET && slot_fill[key] < ENTRIES_PER_KEY &&
        (slot_fill[key] == 0 || stamp > slot_stamps[key][slot_fill[key]-1])) begin
      slot_stamps[key][slot_fill[key]] = stamp;
      slot_fill[key]++;
    end
  endtask

  task automatic wait_for_answers();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    int                 key;
    int                 idx;
    int                 pick;
    int unsigned        inc;
    logic [STAMP_W-1:0] stamp;
    logic [STAMP_W-1:0] last;
    logic               op;

    for (int k = 0; k < KEY_SLOTS; k++) begin
      slot_fill[k] = 0;
    end
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // empty slot, equal and lower stamps, floor between entries, stamp extremes
    send_command(OP_GET, 0, '0, '0);
    send_command(OP_GET, 0, STAMP_MAX, '1);
    send_command(OP_SET, 0, '0, '0);
    send_command(OP_SET, 0, '0, 32'h0000_0001);
    send_command(OP_GET, 0, '0, '1);
    send_command(OP_SET, 0, 31'd100, '1);
    send_command(OP_SET, 0, 31'd50, 32'h1234_5678);
    send_command(OP_GET, 0, 31'd99, '0);
    send_command(OP_GET, 0, 31'd100, '0);
    send_command(OP_GET, 0, STAMP_MAX, '0);
    send_command(OP_SET, 15, STAMP_MAX, 32'hA5A5_A5A5);
    send_command(OP_SET, 15, STAMP_MAX, 32'h5A5A_5A5A);
    send_command(OP_SET, 15, '0, '0);
    send_command(OP_GET, 15, STAMP_MAX - 1'b1, '0);
    send_command(OP_GET, 15, STAMP_MAX, '0);
    send_command(OP_SET, 7, 31'h2AAA_AAAA, 32'h5A5A_5A5A);
    send_command(OP_GET, 7, 31'h5555_5555, '0);
    send_command(OP_GET, 7, 31'h2AAA_AAA9, '0);
    send_command(OP_GET, 3, 31'h5555_5555, '1);
    wait_for_answers();

    for (int n = 0; n < RANDOM_COMMANDS; n++) begin
      if (n % 64 == 0) begin
        back_to_back = ($urandom_range(0, 3) == 0);
      end
      if (n == RANDOM_COMMANDS / 2) begin
        wait_for_answers();
      end
      // a few slots take most sets so that they fill up
      key  = ($urandom_range(0, 9) < 4) ? $urandom_range(0, 3) : $urandom_range(0, KEY_SLOTS-1);
      pick = $urandom_range(0, 99);
      last = (slot_fill[key] > 0) ? slot_stamps[key][slot_fill[key]-1] : '0;
      if (pick < 50) begin
        op = OP_SET;
        if (slot_fill[key] == 0) begin
          stamp = STAMP_W'($urandom_range(32'h7000_0000, 0));
        end else begin
          inc = $urandom_range(1, 1 << $urandom_range(0, 22));
          if (32'(last) + inc > 32'(STAMP_MAX)) begin
            stamp = STAMP_MAX;
          end else begin
            stamp = last + STAMP_W'(inc);
          end
        end
      end else if (pick < 60) begin
        // out of order attempts
        op = OP_SET;
        case ($urandom_range(0, 2))
          0:       stamp = last;
          1:       stamp = last - STAMP_W'($urandom_range(1, 1000));
          default: stamp = '0;
        endcase
        if (slot_fill[key] == 0) begin
          stamp = STAMP_W'($urandom);
        end
      end else begin
        op = OP_GET;
        if (slot_fill[key] == 0) begin
          case ($urandom_range(0, 2))
            0:       stamp = '0;
            1:       stamp = STAMP_MAX;
            default: stamp = STAMP_W'($urandom);
          endcase
        end else begin
          idx = $urandom_range(0, slot_fill[key]-1);
          case ($urandom_range(0, 6))
            0:       stamp = slot_stamps[key][idx];
            1:       stamp = slot_stamps[key][idx] - 1'b1;
            2:       stamp = slot_stamps[key][idx] + 1'b1;
            3:       stamp = slot_stamps[key][0] - 1'b1;
            4:       stamp = '0;
            5:       stamp = STAMP_MAX;
            default: stamp = STAMP_W'($urandom);
          endcase
        end
      end
      send_command(op, key, stamp, pick_value());
    end

    wait_for_answers();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
